FILE: rtl/core/rsv_pkg.sv
// Shared constants, character tables and result type for the identifier checker.
`timescale 1ns / 1ps
package rsv_pkg;

  localparam int MAX_STRING_BYTES = 1024;
  localparam int MIN_STRING_BYTES = 59;
  localparam int POS_W   = $clog2(MAX_STRING_BYTES + 1);
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 11;
  localparam int CNT_W   = 4;

  localparam logic [CNT_W-1:0] PREFIX_LEN     = CNT_W'(7);
  localparam logic [CNT_W-1:0] SERVICE_LEN    = CNT_W'(12);
  localparam logic [CNT_W-1:0] RESOURCE_LEN   = CNT_W'(8);
  localparam logic [CNT_W-1:0] ACCOUNT_DIGITS = CNT_W'(12);
  localparam logic [CNT_W-1:0] CODE_DIGITS    = CNT_W'(13);

  localparam logic [BYTE_W-1:0] COLON_CH = 8'h3A;
  localparam logic [BYTE_W-1:0] SLASH_CH = 8'h2F;
  localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;

  // Fixed words, padded to a power-of-two depth; unused entries never match.
  localparam logic [BYTE_W-1:0] PREFIX_TXT [8] = '{
    8'h61, 8'h72, 8'h6E, 8'h3A, 8'h61, 8'h77, 8'h73, 8'h00
  };
  localparam logic [BYTE_W-1:0] SERVICE_TXT [16] = '{
    8'h6B, 8'h69, 8'h6E, 8'h65, 8'h73, 8'h69, 8'h73, 8'h76,
    8'h69, 8'h64, 8'h65, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [BYTE_W-1:0] RESOURCE_TXT [8] = '{
    8'h63, 8'h68, 8'h61, 8'h6E, 8'h6E, 8'h65, 8'h6C, 8'h2F
  };

  typedef struct packed {
    logic               is_valid;
    logic [FIELD_W-1:0] name_start;
    logic [FIELD_W-1:0] name_length;
  } result_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= DIGIT_LO) && (c <= DIGIT_HI);
  endfunction

endpackage

FILE: rtl/core/rsv_in_if.sv
// Byte request channel: one string character plus its last marker.
`timescale 1ns / 1ps
interface rsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

FILE: rtl/core/rsv_out_if.sv
// Result request channel: verdict and channel name position.
`timescale 1ns / 1ps
interface rsv_out_if;
  logic        valid;
  logic        ready;
  logic        is_valid;
  logic [10:0] name_start;
  logic [10:0] name_length;

  modport source (output valid, output is_valid, output name_start, output name_length,
                  input ready);
  modport sink (input valid, input is_valid, input name_start, input name_length,
                output ready);
endinterface

FILE: rtl/core/rsv_parse.sv
// Parser state and one-byte step of the identifier layout check.
`timescale 1ns / 1ps
module rsv_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [rsv_pkg::BYTE_W-1:0] text_byte,
  input  logic                       final_byte,
  output rsv_pkg::result_t           result
);
  import rsv_pkg::*;

  typedef enum logic [3:0] {
    PH_PREFIX, PH_PARTITION, PH_SERVICE, PH_SERVICE_END, PH_REGION,
    PH_ACCOUNT, PH_RESOURCE, PH_NAME, PH_CODE
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [POS_W-1:0]   name_offset, name_offset_next;
  logic [POS_W-1:0]   name_count, name_count_next;
  logic               failed, failed_next;
  logic               in_range;
  logic               ok;

  assign in_range = pos < POS_W'(MAX_STRING_BYTES);

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    cnt_next         = cnt;
    name_offset_next = name_offset;
    name_count_next  = name_count;
    failed_next      = failed;
    if (!in_range) begin
      failed_next = 1'b1;
    end else begin
      pos_next = pos + POS_W'(1);
      if (!failed) begin
        case (phase)
          PH_PREFIX: begin
            if (cnt >= PREFIX_LEN || text_byte != PREFIX_TXT[cnt[2:0]]) begin
              failed_next = 1'b1;
            end else if (cnt == PREFIX_LEN - CNT_W'(1)) begin
              phase_next = PH_PARTITION;
              cnt_next   = '0;
            end else begin
              cnt_next = cnt + CNT_W'(1);
            end
          end
          PH_PARTITION: begin
            if (text_byte == COLON_CH) begin
              phase_next = PH_SERVICE;
              cnt_next   = '0;
            end
          end
          PH_SERVICE: begin
            if (cnt >= SERVICE_LEN || text_byte != SERVICE_TXT[cnt]) begin
              failed_next = 1'b1;
            end else if (cnt == SERVICE_LEN - CNT_W'(1)) begin
              phase_next = PH_SERVICE_END;
              cnt_next   = '0;
            end else begin
              cnt_next = cnt + CNT_W'(1);
            end
          end
          PH_SERVICE_END: begin
            if (text_byte == COLON_CH) phase_next = PH_REGION;
            else failed_next = 1'b1;
          end
          PH_REGION: begin
            if (text_byte == COLON_CH) begin
              phase_next = PH_ACCOUNT;
              cnt_next   = '0;
            end
          end
          PH_ACCOUNT: begin
            if (cnt < ACCOUNT_DIGITS) begin
              if (is_digit(text_byte)) cnt_next = cnt + CNT_W'(1);
              else failed_next = 1'b1;
            end else if (text_byte == COLON_CH) begin
              phase_next = PH_RESOURCE;
              cnt_next   = '0;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_RESOURCE: begin
            if (cnt >= RESOURCE_LEN || text_byte != RESOURCE_TXT[cnt[2:0]]) begin
              failed_next = 1'b1;
            end else if (cnt == RESOURCE_LEN - CNT_W'(1)) begin
              phase_next       = PH_NAME;
              cnt_next         = '0;
              name_offset_next = pos + POS_W'(1);
              name_count_next  = '0;
            end else begin
              cnt_next = cnt + CNT_W'(1);
            end
          end
          PH_NAME: begin
            if (text_byte == SLASH_CH) begin
              if (name_count == '0) begin
                failed_next = 1'b1;
              end else begin
                phase_next = PH_CODE;
                cnt_next   = '0;
              end
            end else begin
              name_count_next = name_count + POS_W'(1);
            end
          end
          PH_CODE: begin
            if (cnt < CODE_DIGITS && is_digit(text_byte)) cnt_next = cnt + CNT_W'(1);
            else failed_next = 1'b1;
          end
          default: failed_next = 1'b1;
        endcase
      end
    end
  end

  assign ok = !failed_next && phase_next == PH_CODE && cnt_next == CODE_DIGITS &&
              pos >= POS_W'(MIN_STRING_BYTES - 1) && in_range;

  always_comb begin
    result.is_valid    = ok;
    result.name_start  = ok ? FIELD_W'(name_offset_next) : '0;
    result.name_length = ok ? FIELD_W'(name_count_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      phase       <= PH_PREFIX;
      pos         <= '0;
      cnt         <= '0;
      name_offset <= '0;
      name_count  <= '0;
      failed      <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      pos         <= pos_next;
      cnt         <= cnt_next;
      name_offset <= name_offset_next;
      name_count  <= name_count_next;
      failed      <= failed_next;
    end
  end

endmodule

FILE: rtl/core/resource_id_string_validator.sv
// Top level: input register, layout parser and result register of the identifier checker.
// Result path: a last byte's request passes through the input register, then its
//   verdict is loaded into the result register, which drives the output.
// Throughput: one byte per cycle; only a last byte stalls, and only while an
//   earlier result is still waiting at the output.
// Reset: rst (synchronous) empties both registers and returns the parser to the
//   prefix phase at byte offset zero.
`timescale 1ns / 1ps
module resource_id_string_validator (
  input  logic      clk,
  input  logic      rst,
  rsv_in_if.sink    byte_chan,
  rsv_out_if.source result_chan
);
  import rsv_pkg::*;

  // Input register stage
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  // Result register stage
  logic              out_valid;
  result_t           out_result;

  result_t           step_result;
  logic              advance;
  logic              load_result;

  // Hold a last byte while the result slot is full and not being drained;
  // any other byte advances since it produces no result.
  assign advance     = in_valid && (!in_last || !out_valid || result_chan.ready);
  assign load_result = advance && in_last;

  // Take a new request whenever the input register is empty or moving on.
  assign byte_chan.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_chan.ready) begin
      in_valid <= byte_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_chan.ready && byte_chan.valid) begin
      in_byte <= byte_chan.text_byte;
      in_last <= byte_chan.final_byte;
    end
  end

  // Advance the parser by one byte; the last byte also yields the verdict.
  rsv_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .text_byte  (in_byte),
    .final_byte (in_last),
    .result     (step_result)
  );

  // Keep the result until it is taken; drop it on acceptance unless replaced.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_result <= step_result;
    end
  end

  assign result_chan.valid       = out_valid;
  assign result_chan.is_valid    = out_result.is_valid;
  assign result_chan.name_start  = out_result.name_start;
  assign result_chan.name_length = out_result.name_length;

endmodule

FILE: rtl/core/rsv_check.sv
// Port-level assertions for the identifier checker, bound to the top level.
`timescale 1ns / 1ps
module rsv_check (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_is_valid,
  input logic [10:0] res_name_start,
  input logic [10:0] res_name_length
);

  // A waiting result must hold until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_is_valid) &&
    $stable(res_name_start) && $stable(res_name_length))
    else $error("result changed while stalled");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A rejected string reports no name.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_is_valid |-> res_name_start == 11'd0 && res_name_length == 11'd0)
    else $error("invalid result carries a name");

  // An accepted string has a non-empty name past the fixed leading fields.
  a_valid_name: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_is_valid |-> res_name_length != 11'd0 && res_name_start >= 11'd43)
    else $error("valid result with impossible name position");

endmodule

bind resource_id_string_validator rsv_check u_rsv_check (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result_chan.valid),
  .res_ready       (result_chan.ready),
  .res_is_valid    (result_chan.is_valid),
  .res_name_start  (result_chan.name_start),
  .res_name_length (result_chan.name_length)
);
